>>> design/lfup_pkg.sv
// Shared constants for the LFU page replacement block.
package lfup_pkg;

  localparam int PAGE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int FAULT_W = 16;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

endpackage

>>> design/lfu_page_replacement.sv
// Top level of the LFU page replacement block with LRU tie-break.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry page references, one byte each.
//   m_tvalid/m_tready/m_tdata/m_tuser carry one result per reference:
//   m_tuser is the hit flag, m_tdata holds slot, eviction info and the
//   running fault total.
//   cfg_valid/cfg_ready/cfg_data write the active frame count; cfg_ready
//   is always high. Write it only while no reference is in flight.
// Timing:
//   A reference travels down a chain of NUM_FRAMES cells, one cell per
//   cycle; each cell does the hit compare and one victim compare.
//   The result is captured as the beat leaves the last cell and moves to
//   the output register once that register is free; the next reference
//   is accepted only after that move. The table is updated as the beat
//   leaves the last cell.
// Reset: all frames empty, access time and fault count zero, active
//   frame count 8. No clearing pass is needed.
// Stall: a result waits in the output register while m_tready is low;
//   a new reference is taken meanwhile but its result holds until the
//   previous one has been taken.
module lfu_page_replacement #(
  parameter int NUM_FRAMES = 8,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] page
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // [2:0] slot, [3] evicted_valid,
                                                  // [11:4] evicted_page,
                                                  // [27:12] fault_total, [31:28] zero
  output logic                         m_tuser,   // [0] hit
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfup_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [lfup_pkg::CFG_W-1:0]   active_frames;
  logic [TIME_BITS-1:0]         access_time;
  logic [lfup_pkg::FAULT_W-1:0] fault_count;
  logic [lfup_pkg::FAULT_W-1:0] fault_next;

  // pending result
  logic                         res_hit;
  logic [lfup_pkg::SLOT_W-1:0]  res_slot;
  logic                         res_ev_valid;
  logic [lfup_pkg::PAGE_W-1:0]  res_ev_page;
  logic [lfup_pkg::FAULT_W-1:0] res_fault;

  // search chain, stage k feeds cell k
  logic                        ch_valid      [NUM_FRAMES+1];
  logic [lfup_pkg::PAGE_W-1:0] ch_page       [NUM_FRAMES+1];
  logic                        ch_found      [NUM_FRAMES+1];
  logic [IDX_W-1:0]            ch_found_idx  [NUM_FRAMES+1];
  logic                        ch_best_set   [NUM_FRAMES+1];
  logic                        ch_best_valid [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0]       ch_best_uses  [NUM_FRAMES+1];
  logic [TIME_BITS-1:0]        ch_best_last  [NUM_FRAMES+1];
  logic [IDX_W-1:0]            ch_best_idx   [NUM_FRAMES+1];
  logic [lfup_pkg::PAGE_W-1:0] ch_best_page  [NUM_FRAMES+1];

  logic                        s_beat;
  logic                        tail_valid;
  logic                        tail_hit;
  logic [IDX_W-1:0]            tail_idx;
  logic                        out_free;

  assign s_tready  = (state == ST_IDLE);
  assign s_beat    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign ch_valid[0]      = s_beat;
  assign ch_page[0]       = s_tdata[lfup_pkg::PAGE_W-1:0];
  assign ch_found[0]      = 1'b0;
  assign ch_found_idx[0]  = '0;
  assign ch_best_set[0]   = 1'b0;
  assign ch_best_valid[0] = 1'b0;
  assign ch_best_uses[0]  = '0;
  assign ch_best_last[0]  = '0;
  assign ch_best_idx[0]   = '0;
  assign ch_best_page[0]  = '0;

  assign tail_valid = ch_valid[NUM_FRAMES];
  assign tail_hit   = ch_found[NUM_FRAMES];
  assign tail_idx   = tail_hit ? ch_found_idx[NUM_FRAMES] : ch_best_idx[NUM_FRAMES];

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    lfup_cell #(
      .IDX_W      (IDX_W),
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .active         ((i == 0) || (32'(active_frames) > i)),
      .in_valid       (ch_valid[i]),
      .in_page        (ch_page[i]),
      .in_found       (ch_found[i]),
      .in_found_idx   (ch_found_idx[i]),
      .in_best_set    (ch_best_set[i]),
      .in_best_valid  (ch_best_valid[i]),
      .in_best_uses   (ch_best_uses[i]),
      .in_best_last   (ch_best_last[i]),
      .in_best_idx    (ch_best_idx[i]),
      .in_best_page   (ch_best_page[i]),
      .out_valid      (ch_valid[i+1]),
      .out_page       (ch_page[i+1]),
      .out_found      (ch_found[i+1]),
      .out_found_idx  (ch_found_idx[i+1]),
      .out_best_set   (ch_best_set[i+1]),
      .out_best_valid (ch_best_valid[i+1]),
      .out_best_uses  (ch_best_uses[i+1]),
      .out_best_last  (ch_best_last[i+1]),
      .out_best_idx   (ch_best_idx[i+1]),
      .out_best_page  (ch_best_page[i+1]),
      .upd_en         (tail_valid),
      .upd_idx        (tail_idx),
      .upd_hit        (tail_hit),
      .upd_page       (ch_page[NUM_FRAMES]),
      .upd_time       (access_time)
    );
  end

  assign fault_next = (tail_hit || (fault_count == lfup_pkg::FAULT_MAX)) ?
                      fault_count : fault_count + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_beat) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_valid) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_frames <= lfup_pkg::CFG_RESET;
      access_time   <= '0;
      fault_count   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_frames <= cfg_data;
      end
      if (tail_valid) begin
        fault_count <= fault_next;
        if (access_time != TIME_MAX) begin
          access_time <= access_time + 1'b1;
        end
      end
      if (state == ST_HOLD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // capture the result as the beat leaves the chain
  always_ff @(posedge clk) begin
    if (tail_valid) begin
      res_hit      <= tail_hit;
      res_slot     <= lfup_pkg::SLOT_W'(tail_idx);
      res_ev_valid <= !tail_hit && ch_best_valid[NUM_FRAMES];
      res_ev_page  <= (!tail_hit && ch_best_valid[NUM_FRAMES]) ?
                      ch_best_page[NUM_FRAMES] : '0;
      res_fault    <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      m_tuser <= res_hit;
      m_tdata <= {4'b0000, res_fault, res_ev_page, res_ev_valid, res_slot};
    end
  end

  // a beat leaves the chain only while a search is outstanding
  assert property (@(posedge clk) disable iff (rst) tail_valid |-> state == ST_SCAN)
    else $error("search beat left the chain outside a scan");

  // hits never report an eviction
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> !m_tdata[3])
    else $error("hit result carries an eviction");

  // the fault count never goes down
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fault_count >= $past(fault_count))
    else $error("fault count decreased");

  // time advances once per finished reference until it saturates
  assert property (@(posedge clk) disable iff (rst)
    (tail_valid && access_time != TIME_MAX) |=> access_time == $past(access_time) + 1'b1)
    else $error("access time did not advance");

endmodule

>>> design/lfup_cell.sv
// One frame of the replacement table plus its stage of the search chain.
module lfup_cell #(
  parameter int IDX_W      = 3,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32,
  parameter int CELL_IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        active,
  // search beat from the previous cell
  input  logic                        in_valid,
  input  logic [lfup_pkg::PAGE_W-1:0] in_page,
  input  logic                        in_found,
  input  logic [IDX_W-1:0]            in_found_idx,
  input  logic                        in_best_set,
  input  logic                        in_best_valid,
  input  logic [COUNT_BITS-1:0]       in_best_uses,
  input  logic [TIME_BITS-1:0]        in_best_last,
  input  logic [IDX_W-1:0]            in_best_idx,
  input  logic [lfup_pkg::PAGE_W-1:0] in_best_page,
  // search beat to the next cell
  output logic                        out_valid,
  output logic [lfup_pkg::PAGE_W-1:0] out_page,
  output logic                        out_found,
  output logic [IDX_W-1:0]            out_found_idx,
  output logic                        out_best_set,
  output logic                        out_best_valid,
  output logic [COUNT_BITS-1:0]       out_best_uses,
  output logic [TIME_BITS-1:0]        out_best_last,
  output logic [IDX_W-1:0]            out_best_idx,
  output logic [lfup_pkg::PAGE_W-1:0] out_best_page,
  // table update broadcast
  input  logic                        upd_en,
  input  logic [IDX_W-1:0]            upd_idx,
  input  logic                        upd_hit,
  input  logic [lfup_pkg::PAGE_W-1:0] upd_page,
  input  logic [TIME_BITS-1:0]        upd_time
);

  localparam logic [IDX_W-1:0]      MY_IDX   = IDX_W'(CELL_IDX);
  localparam logic [COUNT_BITS-1:0] USES_MAX = '1;

  logic                        valid;
  logic [lfup_pkg::PAGE_W-1:0] page;
  logic [COUNT_BITS-1:0]       uses;
  logic [TIME_BITS-1:0]        last_use;

  logic                  match;
  logic [COUNT_BITS-1:0] eff_uses;
  logic                  better;
  logic                  take;

  assign match    = active && valid && (page == in_page) && !in_found;
  assign eff_uses = valid ? uses : '0;

  always_comb begin
    if (eff_uses != in_best_uses) begin
      better = eff_uses < in_best_uses;
    end else if (valid != in_best_valid) begin
      better = !valid;
    end else if (!valid) begin
      better = 1'b0;
    end else begin
      better = last_use < in_best_last;
    end
  end

  assign take = active && (!in_best_set || better);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_page      <= in_page;
    out_found     <= in_found || match;
    out_found_idx <= match ? MY_IDX : in_found_idx;
    out_best_set  <= in_best_set || take;
    if (take) begin
      out_best_valid <= valid;
      out_best_uses  <= eff_uses;
      out_best_last  <= last_use;
      out_best_idx   <= MY_IDX;
      out_best_page  <= page;
    end else begin
      out_best_valid <= in_best_valid;
      out_best_uses  <= in_best_uses;
      out_best_last  <= in_best_last;
      out_best_idx   <= in_best_idx;
      out_best_page  <= in_best_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd_en && (upd_idx == MY_IDX) && !upd_hit) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && (upd_idx == MY_IDX)) begin
      last_use <= upd_time;
      if (upd_hit) begin
        if (uses != USES_MAX) begin
          uses <= uses + 1'b1;
        end
      end else begin
        page <= upd_page;
        uses <= COUNT_BITS'(1);
      end
    end
  end

endmodule

>>> dv/tb_lfu_page_replacement.sv
// Self-checking stream testbench for the LFU page replacement block.
`timescale 1ns / 100ps

module tb_lfu_page_replacement;

  localparam int PAGE_W  = lfup_pkg::PAGE_W;
  localparam int SLOT_W  = lfup_pkg::SLOT_W;
  localparam int FAULT_W = lfup_pkg::FAULT_W;
  localparam int CFG_W   = lfup_pkg::CFG_W;
  localparam logic [CFG_W-1:0]   CFG_RESET = lfup_pkg::CFG_RESET;
  localparam logic [FAULT_W-1:0] FAULT_MAX = lfup_pkg::FAULT_MAX;

  localparam int FRAMES      = 8;
  localparam int LATENCY     = FRAMES + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [3:0]         pad;
    logic [FAULT_W-1:0] fault_total;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [SLOT_W-1:0]  slot;
  } ref_word_t;

  typedef struct packed {
    logic      hit;
    ref_word_t word;
  } ref_result_t;

  typedef enum logic [1:0] {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  value;
    logic        typed;
    ref_result_t want;
  } dir_row_t;

  localparam ref_result_t NO_WANT = '0;
  localparam int DIR_ROWS = 25;

  // Typed rows: fill from reset; page 0 must not hit an empty frame.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_REF, 8'h00, 1'b1, '{1'b0, '{4'd0, 16'd1, 8'd0, 1'b0, 3'd0}}},
    '{ROW_REF, 8'hFF, 1'b1, '{1'b0, '{4'd0, 16'd2, 8'd0, 1'b0, 3'd1}}},
    '{ROW_REF, 8'h00, 1'b1, '{1'b1, '{4'd0, 16'd2, 8'd0, 1'b0, 3'd0}}},
    '{ROW_REF, 8'h01, 1'b1, '{1'b0, '{4'd0, 16'd3, 8'd0, 1'b0, 3'd2}}},
    '{ROW_REF, 8'h02, 1'b1, '{1'b0, '{4'd0, 16'd4, 8'd0, 1'b0, 3'd3}}},
    '{ROW_REF, 8'h03, 1'b1, '{1'b0, '{4'd0, 16'd5, 8'd0, 1'b0, 3'd4}}},
    '{ROW_REF, 8'h04, 1'b1, '{1'b0, '{4'd0, 16'd6, 8'd0, 1'b0, 3'd5}}},
    '{ROW_REF, 8'h05, 1'b1, '{1'b0, '{4'd0, 16'd7, 8'd0, 1'b0, 3'd6}}},
    '{ROW_REF, 8'h06, 1'b1, '{1'b0, '{4'd0, 16'd8, 8'd0, 1'b0, 3'd7}}},
    '{ROW_REF, 8'h07, 1'b0, NO_WANT},
    '{ROW_REF, 8'h55, 1'b0, NO_WANT},
    '{ROW_REF, 8'hAA, 1'b0, NO_WANT},
    '{ROW_REF, 8'h00, 1'b0, NO_WANT},
    // zero count acts as one frame
    '{ROW_CFG, 8'd0,  1'b0, NO_WANT},
    '{ROW_REF, 8'h03, 1'b0, NO_WANT},
    '{ROW_REF, 8'h03, 1'b0, NO_WANT},
    // oversized count; page 3 now sits in two frames, lower one wins
    '{ROW_CFG, 8'd15, 1'b0, NO_WANT},
    '{ROW_REF, 8'h03, 1'b0, NO_WANT},
    '{ROW_CFG, 8'd3,  1'b0, NO_WANT},
    '{ROW_REF, 8'hFE, 1'b0, NO_WANT},
    '{ROW_REF, 8'h80, 1'b0, NO_WANT},
    '{ROW_CFG, 8'd1,  1'b0, NO_WANT},
    '{ROW_REF, 8'hFF, 1'b0, NO_WANT},
    '{ROW_CFG, 8'd8,  1'b0, NO_WANT},
    '{ROW_REF, 8'h7F, 1'b0, NO_WANT}
  };

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] page
  logic              m_tvalid;
  logic              m_tready;
  logic [31:0]       m_tdata;   // [2:0] slot, [3] evicted_valid, [11:4] evicted_page,
                                // [27:12] fault_total, [31:28] zero
  logic              m_tuser;   // [0] hit
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;

  lfu_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Frame table mirror
  logic [PAGE_W-1:0] fr_page  [FRAMES];
  logic              fr_valid [FRAMES];
  logic [15:0]       fr_uses  [FRAMES];
  logic [31:0]       fr_stamp [FRAMES];
  logic [31:0]       access_now;
  logic [15:0]       fault_run;
  logic [CFG_W-1:0]  active_cfg;

  ref_result_t pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          press_on;
  bit          held_once;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int live_frames(input logic [CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > FRAMES) return FRAMES;
    return int'(cfg);
  endfunction

  function automatic ref_result_t predict_reference(input logic [7:0] pg);
    ref_result_t r;
    int          n;
    int          v;
    bit          found;
    bit          take;
    logic [15:0] ua;
    logic [15:0] ub;
    r     = '0;
    n     = live_frames(active_cfg);
    v     = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && fr_valid[i] && fr_page[i] == pg) begin
        v     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (fr_uses[v] != 16'hFFFF) fr_uses[v] = fr_uses[v] + 16'd1;
      fr_stamp[v] = access_now;
    end else begin
      // lowest count, empty first, then oldest stamp, then lowest frame
      for (int i = 1; i < n; i++) begin
        ua = fr_valid[i] ? fr_uses[i] : 16'd0;
        ub = fr_valid[v] ? fr_uses[v] : 16'd0;
        if (ua != ub) take = ua < ub;
        else if (fr_valid[i] != fr_valid[v]) take = !fr_valid[i];
        else if (!fr_valid[i]) take = 1'b0;
        else take = fr_stamp[i] < fr_stamp[v];
        if (take) v = i;
      end
      if (fr_valid[v]) begin
        r.word.evicted_valid = 1'b1;
        r.word.evicted_page  = fr_page[v];
      end
      fr_page[v]  = pg;
      fr_valid[v] = 1'b1;
      fr_uses[v]  = 16'd1;
      fr_stamp[v] = access_now;
      if (fault_run != FAULT_MAX) fault_run = fault_run + 16'd1;
    end
    if (access_now != 32'hFFFF_FFFF) access_now = access_now + 32'd1;
    r.hit              = found;
    r.word.slot        = SLOT_W'(v);
    r.word.fault_total = fault_run;
    return r;
  endfunction

  // Offer one page; return at the falling edge after the beat.
  task automatic send_page(input logic [7:0] pg, input logic typed,
                           input ref_result_t want);
    ref_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= pg;
    do @(posedge clk); while (!s_tready);
    r = predict_reference(pg);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    active_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    ref_result_t got;
    ref_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.hit  = m_tuser;
      got.word = m_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result hit=%0b data=%h", m_tuser, m_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: hit %0b/%0b slot %0d/%0d ev_valid %0b/%0b ",
                      "ev_page %h/%h faults %0d/%0d pad %h/%h (exp/got)"},
                     exp_r.hit, got.hit, exp_r.word.slot, got.word.slot,
                     exp_r.word.evicted_valid, got.word.evicted_valid,
                     exp_r.word.evicted_page, got.word.evicted_page,
                     exp_r.word.fault_total, got.word.fault_total,
                     exp_r.word.pad, got.word.pad);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL lfu_page_replacement");
      $finish;
    end
  end

  // Receiver: changing stall patterns, one long hold-off on request
  initial begin
    int          stretch;
    int          mode;
    logic [15:0] pat;
    stretch   = 0;
    mode      = 0;
    pat       = 16'h1;
    held_once = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (press_on && !held_once) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(20, 120);
          pat     = 16'($urandom) | 16'h1;
        end
        stretch--;
        case (mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            m_tready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] pool [16];
    int         pool_n;
    int         burst_left;
    int         gap;
    logic [7:0] pg;
    logic [CFG_W-1:0] phase_cfg;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    press_on   = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      fr_page[i]  = '0;
      fr_valid[i] = 1'b0;
      fr_uses[i]  = '0;
      fr_stamp[i] = '0;
    end
    access_now = '0;
    fault_run  = '0;
    active_cfg = CFG_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIRECTED[k].kind == ROW_CFG) begin
        s_tvalid <= 1'b0;
        wait_drained();
        write_frames(DIRECTED[k].value[CFG_W-1:0]);
      end else begin
        send_page(DIRECTED[k].value, DIRECTED[k].typed, DIRECTED[k].want);
      end
    end
    s_tvalid <= 1'b0;

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: phase_cfg = 4'd8;
        1: phase_cfg = 4'd1;
        2: phase_cfg = 4'd0;
        3: phase_cfg = 4'd15;
        4: phase_cfg = 4'd2;
        default: phase_cfg = CFG_W'($urandom_range(0, 15));
      endcase
      write_frames(phase_cfg);
      // working set up to four pages larger than the frame count gives hits and faults
      pool_n = live_frames(phase_cfg) + $urandom_range(0, 4);
      for (int j = 0; j < pool_n; j++) pool[j] = 8'($urandom_range(0, 255));
      if (p == 5) press_on = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        if ($urandom_range(0, 4) == 0) pg = 8'($urandom_range(0, 255));
        else pg = pool[$urandom_range(0, pool_n - 1)];
        send_page(pg, 1'b0, NO_WANT);
      end
      s_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS lfu_page_replacement");
    end else begin
      $display("FAIL lfu_page_replacement");
    end
    $finish;
  end

endmodule
